// ===== sv/pida_pkg.sv =====
`default_nettype none

package pida_pkg;

  localparam int unsigned DataW           = 32;
  localparam int unsigned PosW            = 6;
  localparam int unsigned CountW          = 6;
  localparam int unsigned ReqW            = 2;
  localparam int unsigned StatusW         = 2;
  // Wide enough to index every cell up to the largest supported capacity.
  localparam int unsigned CellIdxW        = 8;
  localparam int unsigned DefaultCapacity = 32;

  localparam logic [ReqW-1:0] ReqInsert   = 2'd0;
  localparam logic [ReqW-1:0] ReqDelete   = 2'd1;
  localparam logic [ReqW-1:0] ReqTraverse = 2'd2;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StRange = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  typedef struct packed {
    logic [ReqW-1:0]         req_type;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       entry_count;
    logic signed [DataW-1:0] element;
    logic                    element_valid;
    logic                    last;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_op_e                op;
    logic [CellIdxW-1:0]     sel_idx;
    logic [CellIdxW-1:0]     end_idx;
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pida_cell.sv =====
`default_nettype none

module pida_cell import pida_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  wire                     clk_i,
  input  cell_cmd_t               cmd_i,
  input  wire signed [DataW-1:0]  left_i,
  input  wire signed [DataW-1:0]  right_i,
  output logic signed [DataW-1:0] entry_o
);

  localparam logic [CellIdxW-1:0] MyIdx = CellIdxW'(INDEX);

  logic signed [DataW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (MyIdx == cmd_i.sel_idx) begin
          entry_d = cmd_i.value;
        end else if (MyIdx > cmd_i.sel_idx) begin
          entry_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= cmd_i.sel_idx) begin
          entry_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // The head entry wraps round to the last occupied cell.
        if (MyIdx < cmd_i.end_idx) begin
          entry_d = right_i;
        end else if (MyIdx == cmd_i.end_idx) begin
          entry_d = cmd_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== sv/positional_insert_delete_array.sv =====
// Insert and delete each act on the whole row of cells at once: every cell shifts together.
// A result is registered and leaves in the cycle after its item is accepted.
// A traverse of N entries starts in the cycle after it is accepted, then gives N results,
// one per free output cycle, rotating the row past the head cell;
// no item is accepted until it ends.
// Reset clears the entry count and the control state; entry contents are not reset.
`default_nettype none

module positional_insert_delete_array import pida_pkg::*; #(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic              out_free;
  logic [CmpW-1:0]   pos_ext, cnt_ext;
  cell_cmd_t         cmd;

  logic signed [DataW-1:0] cell_val [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    pida_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_val),
      .right_i(right_val),
      .entry_o(cell_val[g])
    );
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_TRAV) || !out_free;
  assign pos_ext    = CmpW'(in_item_i.position);
  assign cnt_ext    = CmpW'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    cmd.op      = CELL_HOLD;
    cmd.sel_idx = CellIdxW'(in_item_i.position) - CellIdxW'(1);
    cmd.end_idx = CellIdxW'(count_q - CntW'(1));
    cmd.value   = in_item_i.value;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && out_free) begin
          out_item_d.status        = StOk;
          out_item_d.element       = '0;
          out_item_d.element_valid = 1'b0;
          out_item_d.last          = 1'b1;
          case (in_item_i.req_type)
            ReqInsert: begin
              out_valid_d = 1'b1;
              if (count_q >= CntW'(CAPACITY)) begin
                out_item_d.status = StFull;
              end else if (in_item_i.position == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
                out_item_d.status = StRange;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
              out_item_d.entry_count = CountW'(count_d);
            end
            ReqDelete: begin
              out_valid_d = 1'b1;
              if (in_item_i.position == '0 || pos_ext > cnt_ext) begin
                out_item_d.status = StRange;
              end else begin
                cmd.op  = CELL_DELETE;
                count_d = count_q - CntW'(1);
              end
              out_item_d.entry_count = CountW'(count_d);
            end
            ReqTraverse: begin
              if (count_q == '0) begin
                out_valid_d            = 1'b1;
                out_item_d.entry_count = '0;
              end else begin
                state_d = ST_TRAV;
                rem_d   = count_q;
              end
            end
            default: begin
              out_valid_d = out_valid_q && out_stall_i;
            end
          endcase
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.status        = StOk;
          out_item_d.entry_count   = CountW'(count_q);
          out_item_d.element       = cell_val[0];
          out_item_d.element_valid = 1'b1;
          out_item_d.last          = (rem_q == CntW'(1));
          cmd.op                   = CELL_ROTATE;
          cmd.value                = cell_val[0];
          rem_d                    = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== sv/pida_checker.sv =====
`default_nettype none

module pida_checker import pida_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input out_item_t out_item_o
);

  // A result held back by the receiver keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // A traverse streams without gaps once a non-final item is taken.
  a_trav_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last |=> out_valid_o)
    else $error("gap inside a traverse stream");

  // No new item is taken while a traverse is still streaming.
  a_trav_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> in_stall_o)
    else $error("input accepted during a traverse");

  // Results without an entry are single, final and carry a zero element.
  a_no_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.element_valid |-> out_item_o.last && out_item_o.element == '0)
    else $error("result without an entry is malformed");

  // Traverse results always report success.
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.element_valid |-> out_item_o.status == StOk)
    else $error("traverse item with a failure status");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

// ===== test/positional_insert_delete_array_tb.sv =====
`timescale 1ns / 100ps

module positional_insert_delete_array_tb;
  import pida_pkg::*;

  localparam int Cap        = DefaultCapacity;
  localparam int HoldCycles = 200;

  // The fourth request type, which the block ignores.
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Items waiting to be offered, and the results that the accepted items must give.
  in_item_t                pending_items[$];
  out_item_t               expected_results[$];
  logic signed [DataW-1:0] held_entries[$];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int error_count   = 0;

  // Stimulus side view of the entry count, used to pick legal positions.
  int plan_count = 0;
  bit filling    = 1'b1;

  positional_insert_delete_array dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the results of one accepted item and updates the held entries.
  task automatic apply_request(input in_item_t req);
    out_item_t res;
    int        pos;
    res  = '0;
    pos  = int'(req.position);
    res.last = 1'b1;
    case (req.req_type)
      ReqInsert: begin
        if (held_entries.size() >= Cap) begin
          res.status = StFull;
        end else if (pos < 1 || pos > held_entries.size() + 1) begin
          res.status = StRange;
        end else begin
          held_entries.insert(pos - 1, req.value);
          res.status = StOk;
        end
        res.entry_count = CountW'(held_entries.size());
        expected_results.push_back(res);
      end
      ReqDelete: begin
        if (pos < 1 || pos > held_entries.size()) begin
          res.status = StRange;
        end else begin
          held_entries.delete(pos - 1);
          res.status = StOk;
        end
        res.entry_count = CountW'(held_entries.size());
        expected_results.push_back(res);
      end
      ReqTraverse: begin
        res.status = StOk;
        if (held_entries.size() == 0) begin
          expected_results.push_back(res);
        end else begin
          for (int i = 0; i < held_entries.size(); i++) begin
            res.entry_count   = CountW'(held_entries.size());
            res.element       = held_entries[i];
            res.element_valid = 1'b1;
            res.last          = (i == held_entries.size() - 1);
            expected_results.push_back(res);
          end
        end
      end
      default: begin
        // The fourth request type is ignored by the block.
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          apply_request(in_item_i);
        end
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: %p", out_item_o);
          error_count++;
        end else begin
          exp_item = expected_results.pop_front();
          if (out_item_o.status !== exp_item.status) begin
            $error("status: expected %0d, got %0d", exp_item.status, out_item_o.status);
            error_count++;
          end
          if (out_item_o.entry_count !== exp_item.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   exp_item.entry_count, out_item_o.entry_count);
            error_count++;
          end
          if (out_item_o.element !== exp_item.element) begin
            $error("element: expected %0d, got %0d", exp_item.element, out_item_o.element);
            error_count++;
          end
          if (out_item_o.element_valid !== exp_item.element_valid) begin
            $error("element_valid: expected %0d, got %0d",
                   exp_item.element_valid, out_item_o.element_valid);
            error_count++;
          end
          if (out_item_o.last !== exp_item.last) begin
            $error("last: expected %0d, got %0d", exp_item.last, out_item_o.last);
            error_count++;
          end
        end
      end
    end
  end

  // A requested hold-off keeps the output stalled for a long stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        out_stall_i <= 1'b1;
        hold_left   <= HoldCycles;
        hold_served <= hold_served + 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic push_req(input logic [ReqW-1:0] kind, input int pos,
                          input logic [DataW-1:0] val);
    in_item_t item;
    item.req_type = kind;
    item.position = PosW'(pos);
    item.value    = val;
    pending_items.push_back(item);
    if (kind == ReqInsert && plan_count < Cap && pos >= 1 && pos <= plan_count + 1) begin
      plan_count++;
    end else if (kind == ReqDelete && pos >= 1 && pos <= plan_count) begin
      plan_count--;
    end
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal inserts and deletes, swinging the array between empty and full.
  task automatic queue_random(input int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_req(ReqTraverse, $urandom_range(63), pick_value());
      end else if (pick < 20) begin
        push_req(ReqW'($urandom_range(3)), $urandom_range(63), pick_value());
      end else if (filling) begin
        if (plan_count == Cap) begin
          if ($urandom_range(1) == 1) begin
            push_req(ReqInsert, $urandom_range(63), pick_value());
          end else begin
            filling = 1'b0;
            push_req(ReqDelete, $urandom_range(plan_count, 1), pick_value());
          end
        end else if (pick < 80 || plan_count == 0) begin
          push_req(ReqInsert, $urandom_range(plan_count + 1, 1), pick_value());
        end else begin
          push_req(ReqDelete, $urandom_range(plan_count, 1), pick_value());
        end
      end else begin
        if (plan_count == 0) begin
          filling = 1'b1;
          push_req(ReqInsert, 1, pick_value());
        end else if (pick < 80 || plan_count == Cap) begin
          push_req(ReqDelete, $urandom_range(plan_count, 1), pick_value());
        end else begin
          push_req(ReqInsert, $urandom_range(plan_count + 1, 1), pick_value());
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input bit hold);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) begin
      hold_requests++;
    end
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(ReqTraverse, 0, '0);
    push_req(ReqDelete, 1, '0);
    push_req(ReqInsert, 0, 32'h1234_5678);
    push_req(ReqInsert, 2, 32'h1234_5678);
    push_req(ReqInsert, 1, 32'h8000_0000);
    push_req(ReqInsert, 2, 32'h7fff_ffff);
    push_req(ReqInsert, 1, 32'hffff_ffff);
    push_req(ReqInsert, 2, '0);
    push_req(ReqInsert, 5, 32'h5a5a_5a5a);
    push_req(ReqInsert, 7, 32'h0000_0001);
    push_req(ReqInsert, 63, 32'ha5a5_a5a5);
    push_req(ReqTraverse, 0, '0);
    push_req(ReqDelete, 0, '0);
    push_req(ReqDelete, 6, '0);
    push_req(ReqDelete, 63, '1);
    push_req(ReqUnused, 63, '1);
    push_req(ReqDelete, 3, '0);
    push_req(ReqDelete, 4, '0);
    push_req(ReqDelete, 1, '0);
    push_req(ReqTraverse, 0, '0);
    push_req(ReqInsert, 32, 32'h0bad_cafe);
    push_req(ReqTraverse, 63, '1);
    wait_drained();

    run_phase(0, 0, 80, 1'b1);
    run_phase(63, 0, 70, 1'b0);
    run_phase(0, 63, 70, 1'b0);
    run_phase(22, 22, 68, 1'b0);

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
